// ===== hdl/rcsf_pkg.sv =====
// shared types, constants and field layout for the rc source failover slew arbiter
`default_nettype none

package rcsf_pkg;

    // axis layout
    localparam int PHYS_AXES  = 3;
    localparam int AXIS_COUNT = 3;
    localparam int LANE_COUNT = (AXIS_COUNT < PHYS_AXES) ? AXIS_COUNT : PHYS_AXES;

    // field widths
    localparam int PULSE_W   = 12;
    localparam int FLAGS_W   = 5;
    localparam int TS_W      = 32;
    localparam int GEN_W     = 16;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 10;
    localparam int RATE_W    = 16;

    // stream widths
    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = FLAGS_W;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 1;

    // slew arithmetic
    localparam logic [PULSE_W-1:0] AXIS_MID = 12'd1500;
    localparam int SLEW_DIV    = 1000;
    localparam int PROD_W      = RATE_W + DT_W;
    localparam int QUO_W       = 17;
    localparam int REM_W       = 10;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SLEW_DIV) - 64'd1) / 64'(SLEW_DIV);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];

    // register reset values
    localparam logic [11:0] AUTH_THR_RST  = 12'd1700;
    localparam logic [11:0] TAKEOVER_RST  = 12'd100;
    localparam logic [15:0] TIMEOUT_RST   = 16'd200;
    localparam logic [15:0] SLEW_RATE_RST = 16'd600;
    localparam logic [9:0]  MAX_DT_RST    = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTH_THR  = 3'd0,
        CFG_TAKEOVER  = 3'd1,
        CFG_TIMEOUT   = 3'd2,
        CFG_SLEW_RATE = 3'd3,
        CFG_MAX_DT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        RSN_NONE         = 4'd0,
        RSN_PHYS_INVALID = 4'd1,
        RSN_CONFIG       = 4'd2,
        RSN_DISARMED     = 4'd3,
        RSN_INHIBIT      = 4'd4,
        RSN_REVOKED      = 4'd5,
        RSN_TAKEOVER     = 4'd6,
        RSN_INVALID      = 4'd7,
        RSN_RESTART      = 4'd8,
        RSN_TIMEOUT      = 4'd9
    } t_reason;

    typedef struct packed {
        logic [11:0]       auth_thr;
        logic [11:0]       takeover;
        logic [15:0]       timeout;
        logic [RATE_W-1:0] slew_rate;
        logic [DT_W-1:0]   max_dt;
    } t_cfg;

    // per-beat context carried down the pipeline
    typedef struct packed {
        logic [PHYS_AXES-1:0][PULSE_W-1:0] phys;
        logic [PHYS_AXES-1:0][PULSE_W-1:0] tgt;
        logic [GEN_W-1:0]                  gen;
        logic                              pvalid;
        logic                              armed;
        logic                              chan_ok;
        logic                              inhibit;
        logic                              cvalid;
        logic                              authorized;
        logic                              takeover;
        logic                              fresh;
    } t_ctx;

    // rate times dt split into whole steps and a remainder
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_step;

endpackage

`default_nettype wire

// ===== hdl/rcsf_front.sv =====
// input stage: field unpacking, gate predicates, targets and capped elapsed time
`default_nettype none

module rcsf_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rcsf_pkg::IN_DATA_W-1:0] i_data,
    input  wire logic [rcsf_pkg::IN_USER_W-1:0] i_user,
    input  rcsf_pkg::t_cfg                      i_cfg,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output rcsf_pkg::t_ctx                      o_ctx,
    output logic [rcsf_pkg::DT_W-1:0]           o_dt
);
    import rcsf_pkg::*;

    localparam int OFF_AUTH = PHYS_AXES * PULSE_W;
    localparam int OFF_RECV = OFF_AUTH + PULSE_W;
    localparam int OFF_GEN  = OFF_RECV + TS_W;
    localparam int OFF_CAND = OFF_GEN + GEN_W;
    localparam int OFF_NOW  = OFF_CAND + PHYS_AXES * PULSE_W;

    localparam int FLAG_PVALID  = 0;
    localparam int FLAG_ARMED   = 1;
    localparam int FLAG_CHAN_OK = 2;
    localparam int FLAG_INHIBIT = 3;
    localparam int FLAG_CVALID  = 4;

    logic               r_valid;
    t_ctx               r_ctx;
    logic [DT_W-1:0]    r_dt;
    logic [TS_W-1:0]    r_prev_ms;

    t_ctx               n_ctx;
    logic [DT_W-1:0]    n_dt;
    logic               w_load;
    logic [PULSE_W-1:0] w_auth;
    logic [TS_W-1:0]    w_recv;
    logic [TS_W-1:0]    w_now;
    logic [TS_W-1:0]    w_age;
    logic [TS_W-1:0]    w_elapsed;

    function automatic logic [PULSE_W-1:0] dist_mid(input logic [PULSE_W-1:0] v);
        return (v >= AXIS_MID) ? (v - AXIS_MID) : (AXIS_MID - v);
    endfunction

    // 1500 plus signed offset, floored at zero (the top end cannot overflow)
    function automatic logic [PULSE_W-1:0] target_of(input logic [PULSE_W-1:0] off);
        logic signed [PULSE_W:0] t;
        t = $signed({1'b0, AXIS_MID}) + $signed({off[PULSE_W-1], off});
        return t[PULSE_W] ? '0 : t[PULSE_W-1:0];
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    assign w_auth    = i_data[OFF_AUTH +: PULSE_W];
    assign w_recv    = i_data[OFF_RECV +: TS_W];
    assign w_now     = i_data[OFF_NOW +: TS_W];
    assign w_age     = w_now - w_recv;
    assign w_elapsed = w_now - r_prev_ms;

    // elapsed ms since the previous beat, capped
    assign n_dt = (w_elapsed > TS_W'(i_cfg.max_dt)) ? i_cfg.max_dt : w_elapsed[DT_W-1:0];

    // unpack and evaluate predicates
    always_comb begin
        n_ctx.takeover = 1'b0;
        for (int a = 0; a < PHYS_AXES; a++) begin
            n_ctx.phys[a] = i_data[a*PULSE_W +: PULSE_W];
            n_ctx.tgt[a]  = target_of(i_data[OFF_CAND + a*PULSE_W +: PULSE_W]);
            n_ctx.takeover = n_ctx.takeover ||
                             (dist_mid(i_data[a*PULSE_W +: PULSE_W]) > i_cfg.takeover);
        end
        n_ctx.gen        = i_data[OFF_GEN +: GEN_W];
        n_ctx.pvalid     = i_user[FLAG_PVALID];
        n_ctx.armed      = i_user[FLAG_ARMED];
        n_ctx.chan_ok    = i_user[FLAG_CHAN_OK];
        n_ctx.inhibit    = i_user[FLAG_INHIBIT];
        n_ctx.cvalid     = i_user[FLAG_CVALID];
        n_ctx.authorized = (w_auth >= i_cfg.auth_thr);
        n_ctx.fresh      = i_user[FLAG_CVALID] && (w_age < TS_W'(i_cfg.timeout));
    end

    // stage valid and last timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_prev_ms <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_prev_ms <= w_now;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ctx <= n_ctx;
            r_dt  <= n_dt;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_dt    = r_dt;

endmodule

`default_nettype wire

// ===== hdl/rcsf_slew_prep.sv =====
// rate times dt, then split by 1000 into whole steps and a remainder over three stages
`default_nettype none

module rcsf_slew_prep (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  rcsf_pkg::t_ctx                    i_ctx,
    input  wire logic [rcsf_pkg::DT_W-1:0]    i_dt,
    input  wire logic [rcsf_pkg::RATE_W-1:0]  i_rate,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output rcsf_pkg::t_ctx                    o_ctx,
    output rcsf_pkg::t_step                   o_step
);
    import rcsf_pkg::*;

    logic                       r_vb;
    logic                       r_vc;
    logic                       r_vd;
    t_ctx                       r_ctx_b;
    t_ctx                       r_ctx_c;
    t_ctx                       r_ctx_d;
    logic [PROD_W-1:0]          r_prod_b;
    logic [PROD_W-1:0]          r_prod_c;
    logic [QUO_W-1:0]           r_quo_c;
    t_step                      r_step_d;

    logic                       w_rdy_b;
    logic                       w_rdy_c;
    logic                       w_rdy_d;
    logic [PROD_W-1:0]          n_prod;
    logic [PROD_W+RECIP_W-1:0]  w_recip;
    logic [QUO_W-1:0]           n_quo;
    logic [PROD_W-1:0]          w_back;
    logic [PROD_W-1:0]          w_diff;
    t_step                      n_step;

    assign w_rdy_d = !r_vd || i_ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign o_ready = w_rdy_b;

    // rate times capped dt
    assign n_prod = PROD_W'(i_rate) * PROD_W'(i_dt);

    // quotient by 1000 through the reciprocal, exact over the product range
    assign w_recip = (PROD_W+RECIP_W)'(r_prod_b) * (PROD_W+RECIP_W)'(RECIP_M);
    assign n_quo   = w_recip[RECIP_SHIFT +: QUO_W];

    // remainder from the registered quotient
    assign w_back       = PROD_W'(r_quo_c) * PROD_W'(SLEW_DIV);
    assign w_diff       = r_prod_c - w_back;
    assign n_step.quo   = r_quo_c;
    assign n_step.rem   = w_diff[REM_W-1:0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_b) begin
                r_vb <= i_valid;
            end
            if (w_rdy_c) begin
                r_vc <= r_vb;
            end
            if (w_rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_rdy_b && i_valid) begin
            r_ctx_b  <= i_ctx;
            r_prod_b <= n_prod;
        end
        if (w_rdy_c && r_vb) begin
            r_ctx_c  <= r_ctx_b;
            r_prod_c <= r_prod_b;
            r_quo_c  <= n_quo;
        end
        if (w_rdy_d && r_vc) begin
            r_ctx_d  <= r_ctx_c;
            r_step_d <= n_step;
        end
    end

    assign o_valid = r_vd;
    assign o_ctx   = r_ctx_d;
    assign o_step  = r_step_d;

endmodule

`default_nettype wire

// ===== hdl/rcsf_lane.sv =====
// one axis slew lane: holds the axis value and its remainder, steps toward the target
`default_nettype none

module rcsf_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_update,
    input  wire logic                          i_enter,
    input  wire logic [rcsf_pkg::PULSE_W-1:0]  i_phys,
    input  wire logic [rcsf_pkg::PULSE_W-1:0]  i_tgt,
    input  rcsf_pkg::t_step                    i_step,
    output logic [rcsf_pkg::PULSE_W-1:0]       o_value
);
    import rcsf_pkg::*;

    logic [PULSE_W-1:0] r_value;
    logic [REM_W-1:0]   r_rem;

    logic [PULSE_W-1:0] n_value;
    logic [REM_W-1:0]   n_rem;
    logic [PULSE_W-1:0] w_cur;
    logic [REM_W-1:0]   w_rem;
    logic [REM_W:0]     w_sum;
    logic               w_carry;
    logic [REM_W:0]     w_wrap;
    logic [QUO_W-1:0]   w_step;
    logic               w_up;
    logic [PULSE_W-1:0] w_delta;
    logic               w_reach;

    // entry starts from the physical pulse with a cleared remainder
    assign w_cur = i_enter ? i_phys : r_value;
    assign w_rem = i_enter ? '0 : r_rem;

    // carry the remainder into the step
    assign w_sum   = (REM_W+1)'(w_rem) + (REM_W+1)'(i_step.rem);
    assign w_carry = (w_sum >= (REM_W+1)'(SLEW_DIV));
    assign w_wrap  = w_carry ? (w_sum - (REM_W+1)'(SLEW_DIV)) : w_sum;
    assign w_step  = i_step.quo + QUO_W'(w_carry);

    assign w_up    = (w_cur < i_tgt);
    assign w_delta = w_up ? (i_tgt - w_cur) : (w_cur - i_tgt);
    assign w_reach = (QUO_W'(w_delta) <= w_step);

    // step toward the target without overshoot
    always_comb begin
        priority if (w_cur == i_tgt) begin
            n_value = w_cur;
            n_rem   = '0;
        end else if (w_step == '0) begin
            n_value = w_cur;
            n_rem   = w_wrap[REM_W-1:0];
        end else if (w_reach) begin
            n_value = i_tgt;
            n_rem   = w_wrap[REM_W-1:0];
        end else begin
            n_value = w_up ? (w_cur + w_step[PULSE_W-1:0]) : (w_cur - w_step[PULSE_W-1:0]);
            n_rem   = w_wrap[REM_W-1:0];
        end
    end

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_rem   <= '0;
        end else if (i_update) begin
            r_value <= n_value;
            r_rem   <= n_rem;
        end
    end

    assign o_value = n_value;

endmodule

`default_nettype wire

// ===== hdl/rc_source_failover_slew_arbiter_core.sv =====
// top level: config registers, source arbitration, axis lanes and output register
// A result beat passes the front register, three slew stages and the output register.
// Throughput: one beat per cycle; the divide by 1000 runs ahead in three stages.
// A stalled result holds the output; earlier stages fill, then the input stalls.
// Reset is synchronous and active low: source, counters, axes and registers
// return to their defaults; no clearing pass is needed.
`default_nettype none

module rc_source_failover_slew_arbiter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // phys_roll, phys_pitch, phys_yaw, auth_pulse, cand_received_ms,
    // cand_generation, cand_roll, cand_pitch, cand_yaw, now_ms, zero pad
    input  wire logic [rcsf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // gate_flags
    input  wire logic [rcsf_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // out_roll, out_pitch, out_yaw, exit_reason, auth_active,
    // activation_total, exit_total, zero pad
    output logic [rcsf_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // virtual_active
    output logic [rcsf_pkg::OUT_USER_W-1:0]      o_m_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic                            i_cfg_we,
    input  wire logic [rcsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rcsf_pkg::CFG_W-1:0]      i_cfg_data
);
    import rcsf_pkg::*;

    t_cfg                               r_cfg;
    logic                               r_virtual;
    logic                               r_seen_low;
    t_reason                            r_reason;
    logic [GEN_W-1:0]                   r_session_gen;
    logic [CNT_W-1:0]                   r_entries;
    logic [CNT_W-1:0]                   r_exits;
    logic                               r_out_valid;
    logic [OUT_DATA_W-1:0]              r_out_data;
    logic [OUT_USER_W-1:0]              r_out_user;

    logic                               n_virtual;
    logic                               n_seen_low;
    t_reason                            n_reason;
    logic [GEN_W-1:0]                   n_session_gen;
    logic [CNT_W-1:0]                   n_entries;
    logic [CNT_W-1:0]                   n_exits;
    logic [OUT_DATA_W-1:0]              n_out_data;

    logic                               w_front_valid;
    logic                               w_front_ready;
    t_ctx                               w_front_ctx;
    logic [DT_W-1:0]                    w_front_dt;
    logic                               w_d_valid;
    t_ctx                               w_ctx;
    t_step                              w_step;
    logic                               w_out_ready;
    logic                               w_xfer;
    logic                               w_enter;
    t_reason                            w_exit_rsn;
    logic [PHYS_AXES-1:0][PULSE_W-1:0]  w_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auth_thr  <= AUTH_THR_RST;
            r_cfg.takeover  <= TAKEOVER_RST;
            r_cfg.timeout   <= TIMEOUT_RST;
            r_cfg.slew_rate <= SLEW_RATE_RST;
            r_cfg.max_dt    <= MAX_DT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AUTH_THR:  r_cfg.auth_thr  <= i_cfg_data[11:0];
                CFG_TAKEOVER:  r_cfg.takeover  <= i_cfg_data[11:0];
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data[15:0];
                CFG_SLEW_RATE: r_cfg.slew_rate <= i_cfg_data[RATE_W-1:0];
                CFG_MAX_DT:    r_cfg.max_dt    <= i_cfg_data[DT_W-1:0];
                default: ;
            endcase
        end
    end

    rcsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_user  (i_s_tuser),
        .i_cfg   (r_cfg),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready),
        .o_ctx   (w_front_ctx),
        .o_dt    (w_front_dt)
    );

    rcsf_slew_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_ctx   (w_front_ctx),
        .i_dt    (w_front_dt),
        .i_rate  (r_cfg.slew_rate),
        .o_valid (w_d_valid),
        .i_ready (w_out_ready),
        .o_ctx   (w_ctx),
        .o_step  (w_step)
    );

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_xfer      = w_d_valid && w_out_ready;

    // first failing condition in priority order
    always_comb begin
        priority if (!w_ctx.pvalid)                w_exit_rsn = RSN_PHYS_INVALID;
        else if (!w_ctx.chan_ok)                   w_exit_rsn = RSN_CONFIG;
        else if (!w_ctx.armed)                     w_exit_rsn = RSN_DISARMED;
        else if (w_ctx.inhibit)                    w_exit_rsn = RSN_INHIBIT;
        else if (!w_ctx.authorized)                w_exit_rsn = RSN_REVOKED;
        else if (w_ctx.takeover)                   w_exit_rsn = RSN_TAKEOVER;
        else if (!w_ctx.cvalid)                    w_exit_rsn = RSN_INVALID;
        else if (w_ctx.gen != r_session_gen)       w_exit_rsn = RSN_RESTART;
        else if (!w_ctx.fresh)                     w_exit_rsn = RSN_TIMEOUT;
        else                                       w_exit_rsn = RSN_NONE;
    end

    // source arbitration
    always_comb begin
        n_virtual     = r_virtual;
        n_seen_low    = r_seen_low || (w_ctx.pvalid && !w_ctx.authorized);
        n_reason      = r_reason;
        n_session_gen = r_session_gen;
        n_entries     = r_entries;
        n_exits       = r_exits;
        w_enter       = 1'b0;
        if (r_virtual) begin
            if (w_exit_rsn != RSN_NONE) begin
                n_virtual  = 1'b0;
                n_reason   = w_exit_rsn;
                n_seen_low = 1'b0;
                n_exits    = r_exits + CNT_W'(1);
            end
        end else if (w_ctx.pvalid && w_ctx.chan_ok && w_ctx.armed && !w_ctx.inhibit &&
                     w_ctx.authorized && n_seen_low && !w_ctx.takeover && w_ctx.fresh) begin
            n_virtual     = 1'b1;
            n_seen_low    = 1'b0;
            n_reason      = RSN_NONE;
            n_session_gen = w_ctx.gen;
            n_entries     = r_entries + CNT_W'(1);
            w_enter       = 1'b1;
        end
    end

    // axis lanes, the rest pass the physical pulse through
    for (genvar g = 0; g < PHYS_AXES; g++) begin : g_axis
        if (g < LANE_COUNT) begin : g_lane
            logic [PULSE_W-1:0] w_lane_val;

            rcsf_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_update (w_xfer && n_virtual),
                .i_enter  (w_enter),
                .i_phys   (w_ctx.phys[g]),
                .i_tgt    (w_ctx.tgt[g]),
                .i_step   (w_step),
                .o_value  (w_lane_val)
            );

            assign w_res[g] = n_virtual ? w_lane_val : w_ctx.phys[g];
        end else begin : g_pass
            assign w_res[g] = w_ctx.phys[g];
        end
    end

    // merge lane results and status into the result beat
    assign n_out_data = {7'b0, n_exits, n_entries, w_ctx.authorized, n_reason,
                         w_res[2], w_res[1], w_res[0]};

    // arbitration state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_virtual     <= 1'b0;
            r_seen_low    <= 1'b0;
            r_reason      <= RSN_NONE;
            r_session_gen <= '0;
            r_entries     <= '0;
            r_exits       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_out_ready) begin
                r_out_valid <= w_d_valid;
            end
            if (w_xfer) begin
                r_virtual     <= n_virtual;
                r_seen_low    <= n_seen_low;
                r_reason      <= n_reason;
                r_session_gen <= n_session_gen;
                r_entries     <= n_entries;
                r_exits       <= n_exits;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_data <= n_out_data;
            r_out_user <= n_virtual;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== hdl/rcsf_checker.sv =====
// port-level checks for the arbiter core, bound to the top level
`default_nettype none

module rcsf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [rcsf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic [rcsf_pkg::OUT_USER_W-1:0] o_m_tuser
);
    import rcsf_pkg::*;

    logic [3:0]       w_reason;
    logic [CNT_W-1:0] w_entries;
    logic [CNT_W-1:0] w_exits;
    logic [CNT_W-1:0] w_gap;

    assign w_reason  = o_m_tdata[39:36];
    assign w_entries = o_m_tdata[72:41];
    assign w_exits   = o_m_tdata[104:73];
    assign w_gap     = w_entries - w_exits;

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // nothing pending out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // entries and exits alternate, so their gap is the virtual flag
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_gap == CNT_W'(o_m_tuser))
        else $error("entry and exit counts disagree with source");

    // an active virtual source always shows no exit reason
    a_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> w_reason == RSN_NONE)
        else $error("exit reason set while virtual");

endmodule

bind rc_source_failover_slew_arbiter_core rcsf_checker u_checker (.*);

`default_nettype wire

// ===== sim/rc_source_failover_slew_arbiter_core_tb.sv =====
// self-checking testbench for the rc source failover slew arbiter core
`default_nettype none

module rc_source_failover_slew_arbiter_core_tb;
    import rcsf_pkg::*;

    // gate flag bit positions in tuser
    localparam int GATE_PVALID  = 0;
    localparam int GATE_ARMED   = 1;
    localparam int GATE_CHAN    = 2;
    localparam int GATE_INHIBIT = 3;
    localparam int GATE_CVALID  = 4;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [31:0]      now;
        logic [2:0][11:0] offs;
        logic [15:0]      gen;
        logic [31:0]      recv;
        logic [11:0]      auth;
        logic [2:0][11:0] phys;
        logic [4:0]       flags;
    } stick_update_t;

    typedef struct {
        logic [2:0][11:0] axes;
        logic             virt;
        logic [3:0]       reason;
        logic             auth_hit;
        logic [31:0]      entries;
        logic [31:0]      exits;
    } arbiter_result_t;

    // source arbitration and slew tracker, with the results still owed by the block
    class failover_scoreboard;
        logic [11:0] auth_thr;
        logic [11:0] takeover;
        logic [15:0] timeout_ms;
        logic [15:0] slew_rate;
        logic [9:0]  max_dt;

        bit          virt;
        bit          seen_low;
        logic [3:0]  last_reason;
        logic [15:0] sess_gen;
        logic [31:0] entries;
        logic [31:0] exits;
        logic [31:0] last_now;
        logic [11:0] lane_value [3];
        logic [9:0]  lane_rem [3];

        arbiter_result_t results_due [$];
        int mismatches;
        int checked;

        function new();
            auth_thr    = AUTH_THR_RST;
            takeover    = TAKEOVER_RST;
            timeout_ms  = TIMEOUT_RST;
            slew_rate   = SLEW_RATE_RST;
            max_dt      = MAX_DT_RST;
            virt        = 0;
            seen_low    = 0;
            last_reason = RSN_NONE;
            sess_gen    = '0;
            entries     = '0;
            exits       = '0;
            last_now    = '0;
            for (int i = 0; i < 3; i++) begin
                lane_value[i] = '0;
                lane_rem[i]   = '0;
            end
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_AUTH_THR:  auth_thr   = value[11:0];
                CFG_TAKEOVER:  takeover   = value[11:0];
                CFG_TIMEOUT:   timeout_ms = value;
                CFG_SLEW_RATE: slew_rate  = value;
                CFG_MAX_DT:    max_dt     = value[9:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] mid_distance(logic [11:0] v);
            return (v >= AXIS_MID) ? v - AXIS_MID : AXIS_MID - v;
        endfunction

        function arbiter_result_t arbitrate_update(stick_update_t u);
            arbiter_result_t r;
            logic [11:0] target [3];
            logic [31:0] age, dt, scaled, step;
            bit pvalid, armed, chan_ok, inhibit, cvalid, authorized, took_over, fresh;
            int off, t, i;
            t_reason why;

            pvalid  = u.flags[GATE_PVALID];
            armed   = u.flags[GATE_ARMED];
            chan_ok = u.flags[GATE_CHAN];
            inhibit = u.flags[GATE_INHIBIT];
            cvalid  = u.flags[GATE_CVALID];
            took_over = 0;
            // saturated targets and stick deviation
            for (i = 0; i < PHYS_AXES; i++) begin
                off = int'($signed(u.offs[i]));
                t = int'(AXIS_MID) + off;
                target[i] = (t < 0) ? 12'd0 : (t > 4095) ? 12'd4095 : 12'(t);
                if (mid_distance(u.phys[i]) > takeover) took_over = 1;
            end
            authorized = u.auth >= auth_thr;
            age = u.now - u.recv;
            fresh = cvalid && (age < {16'd0, timeout_ms});

            if (pvalid && !authorized) seen_low = 1;

            // exit in priority order, or entry when every gate holds
            why = RSN_NONE;
            if (virt) begin
                if (!pvalid)               why = RSN_PHYS_INVALID;
                else if (!chan_ok)         why = RSN_CONFIG;
                else if (!armed)           why = RSN_DISARMED;
                else if (inhibit)          why = RSN_INHIBIT;
                else if (!authorized)      why = RSN_REVOKED;
                else if (took_over)        why = RSN_TAKEOVER;
                else if (!cvalid)          why = RSN_INVALID;
                else if (u.gen != sess_gen) why = RSN_RESTART;
                else if (!fresh)           why = RSN_TIMEOUT;
                if (why != RSN_NONE) begin
                    virt        = 0;
                    last_reason = why;
                    seen_low    = 0;
                    exits++;
                end
            end else if (pvalid && chan_ok && armed && !inhibit && authorized &&
                         seen_low && !took_over && fresh) begin
                virt        = 1;
                seen_low    = 0;
                last_reason = RSN_NONE;
                sess_gen    = u.gen;
                entries++;
                for (i = 0; i < PHYS_AXES; i++) begin
                    lane_value[i] = u.phys[i];
                    lane_rem[i]   = '0;
                end
            end

            dt = u.now - last_now;
            last_now = u.now;
            if (dt > {22'd0, max_dt}) dt = {22'd0, max_dt};

            // rate-limited slew of the virtual lanes
            r.axes = u.phys;
            if (virt) begin
                for (i = 0; i < LANE_COUNT; i++) begin
                    if (lane_value[i] == target[i]) begin
                        lane_rem[i] = '0;
                    end else begin
                        scaled = slew_rate * dt + lane_rem[i];
                        step = scaled / SLEW_DIV;
                        lane_rem[i] = 10'(scaled % SLEW_DIV);
                        if (step != 0) begin
                            if (lane_value[i] < target[i])
                                lane_value[i] = (target[i] - lane_value[i] <= step) ?
                                    target[i] : lane_value[i] + 12'(step);
                            else
                                lane_value[i] = (lane_value[i] - target[i] <= step) ?
                                    target[i] : lane_value[i] - 12'(step);
                        end
                    end
                    r.axes[i] = lane_value[i];
                end
            end

            r.virt     = virt;
            r.reason   = last_reason;
            r.auth_hit = authorized;
            r.entries  = entries;
            r.exits    = exits;
            return r;
        endfunction

        function void note_update(stick_update_t u);
            results_due.push_back(arbitrate_update(u));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data,
                                   logic [OUT_USER_W-1:0] user);
            arbiter_result_t want;
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result beat expected none, got tdata %h tuser %b",
                         $time, data, user);
                return;
            end
            want = results_due.pop_front();
            checked++;
            compare_field("out_roll", want.axes[0], data[11:0]);
            compare_field("out_pitch", want.axes[1], data[23:12]);
            compare_field("out_yaw", want.axes[2], data[35:24]);
            compare_field("exit_reason", want.reason, data[39:36]);
            compare_field("auth_active", want.auth_hit, data[40]);
            compare_field("activation_total", want.entries, data[72:41]);
            compare_field("exit_total", want.exits, data[104:73]);
            compare_field("virtual_active", want.virt, user[0]);
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic [IN_DATA_W-1:0]   i_s_tdata  = '0;
    logic [IN_USER_W-1:0]   i_s_tuser  = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic [OUT_USER_W-1:0]  o_m_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    failover_scoreboard sb = new();

    // stimulus state shared by the item builders
    logic [31:0]      clock_ms  = '0;
    logic [15:0]      sess_gen  = '0;
    logic [2:0][11:0] cand_offs = '0;
    bit               send_burst = 0;
    bit               take_burst = 0;
    bit               rst_done   = 0;
    int               settings_used = 0;
    int               cycle_count = 0;

    rc_source_failover_slew_arbiter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // a well-formed update: all gates open, authorized, sticks within the takeover band, fresh candidate
    function automatic stick_update_t nominal_update();
        stick_update_t u;
        int spread, pick, i;
        spread = (sb.takeover > 1500) ? 1500 : int'(sb.takeover);
        pick = $urandom_range(0, 99);
        if (pick < 80)      clock_ms += $urandom_range(0, 40);
        else if (pick < 95) clock_ms += $urandom_range(41, 1500);
        else                clock_ms += $urandom();
        u.now = clock_ms;
        u.flags = '0;
        u.flags[GATE_PVALID] = 1'b1;
        u.flags[GATE_ARMED]  = 1'b1;
        u.flags[GATE_CHAN]   = 1'b1;
        u.flags[GATE_CVALID] = 1'b1;
        u.auth = 12'($urandom_range(sb.auth_thr, 4095));
        for (i = 0; i < 3; i++)
            u.phys[i] = 12'(1500 - spread + $urandom_range(0, 2 * spread));
        if (sb.timeout_ms == 0)
            u.recv = u.now - $urandom_range(0, 50);
        else if ($urandom_range(0, 7) == 0)
            u.recv = u.now - (sb.timeout_ms - 1);
        else
            u.recv = u.now - $urandom_range(0, sb.timeout_ms - 1);
        u.gen  = sess_gen;
        u.offs = cand_offs;
        return u;
    endfunction

    // authorization below threshold arms the seen-low handshake
    function automatic stick_update_t low_auth_update();
        stick_update_t u;
        u = nominal_update();
        if (sb.auth_thr != 0) u.auth = 12'($urandom_range(0, sb.auth_thr - 1));
        return u;
    endfunction

    // well-formed update broken in the one way that gives the named exit
    function automatic stick_update_t disrupted_update(t_reason why);
        stick_update_t u;
        int axis;
        u = nominal_update();
        axis = $urandom_range(0, 2);
        case (why)
            RSN_PHYS_INVALID: u.flags[GATE_PVALID] = 1'b0;
            RSN_CONFIG:       u.flags[GATE_CHAN] = 1'b0;
            RSN_DISARMED:     u.flags[GATE_ARMED] = 1'b0;
            RSN_INHIBIT:      u.flags[GATE_INHIBIT] = 1'b1;
            RSN_REVOKED: begin
                if (sb.auth_thr != 0) u.auth = 12'($urandom_range(0, sb.auth_thr - 1));
            end
            RSN_TAKEOVER: begin
                if (sb.takeover < 1500 && $urandom_range(0, 1) == 0)
                    u.phys[axis] = 12'($urandom_range(0, 1499 - sb.takeover));
                else if (sb.takeover < 2595)
                    u.phys[axis] = 12'($urandom_range(1501 + sb.takeover, 4095));
            end
            RSN_INVALID:  u.flags[GATE_CVALID] = 1'b0;
            RSN_RESTART:  u.gen = u.gen + 16'($urandom_range(1, 65535));
            RSN_TIMEOUT:  u.recv = u.now - (32'(sb.timeout_ms) + $urandom_range(0, 5000));
            default: ;
        endcase
        return u;
    endfunction

    // mostly sessions that reach the virtual source, with breaks and noise
    function automatic stick_update_t random_update();
        stick_update_t u;
        int pick, i;
        if ($urandom_range(0, 9) == 0) begin
            for (i = 0; i < 3; i++) begin
                case ($urandom_range(0, 3))
                    0:       cand_offs[i] = 12'h800;
                    1:       cand_offs[i] = 12'h7FF;
                    2:       cand_offs[i] = 12'h000;
                    default: cand_offs[i] = 12'($urandom());
                endcase
            end
        end
        if ($urandom_range(0, 39) == 0) sess_gen = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            u = nominal_update();
        end else if (pick < 67) begin
            u = low_auth_update();
        end else if (pick < 90) begin
            u = disrupted_update(t_reason'($urandom_range(1, 9)));
        end else begin
            u = stick_update_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom()});
            clock_ms = u.now;
        end
        return u;
    endfunction

    // offer one update beat after a random gap and wait for it to be taken
    task automatic send_update(input stick_update_t u);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {4'b0, u.now, u.offs, u.gen, u.recv, u.auth, u.phys};
        i_s_tuser  <= u.flags;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_update(u);
    endtask

    task automatic drain_results();
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    // new register setting, only once the block has gone quiet
    task automatic apply_setting(input logic [15:0] thr, input logic [15:0] tkv,
                                 input logic [15:0] tmo, input logic [15:0] rate,
                                 input logic [15:0] max_step);
        i_s_tvalid <= 1'b0;
        drain_results();
        write_reg(CFG_AUTH_THR, thr);
        write_reg(CFG_TAKEOVER, tkv);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_SLEW_RATE, rate);
        write_reg(CFG_MAX_DT, max_step);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_update(random_update());
    endtask

    // result side: random stalls, every beat checked against the oldest expectation
    initial begin
        int stall;
        wait (rst_done);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_result(o_m_tdata, o_m_tuser);
        end
    end

    // main sequence
    initial begin
        stick_update_t u;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1;
        settings_used = 1;

        // every exit reason in turn after seen-low and entry, across the ms wrap,
        // with saturating and centred targets
        clock_ms  = 32'hFFFF_FF80;
        sess_gen  = 16'h8001;
        cand_offs = {12'h000, 12'h7FF, 12'h800};
        for (int k = 1; k <= 9; k++) begin
            send_update(low_auth_update());
            send_update(nominal_update());
            if (t_reason'(k) == RSN_PHYS_INVALID) begin
                u = '0;
                clock_ms = u.now;
            end else if (t_reason'(k) == RSN_INHIBIT) begin
                u = '1;
                clock_ms = u.now;
            end else begin
                u = disrupted_update(t_reason'(k));
            end
            send_update(u);
        end

        apply_setting(16'd1700, 16'd100, 16'd200, 16'd600, 16'd100);
        run_random(180);
        // top of the threshold, takeover, timeout and rate ranges
        apply_setting(16'd4095, 16'd4095, 16'd65535, 16'd65535, 16'd1000);
        run_random(140);
        // bottom of the ranges: exact neutral sticks, same-ms candidates, slowest slew
        apply_setting(16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
        run_random(140);
        // zero threshold and zero timeout: nothing is ever fresh
        apply_setting(16'd0, 16'd300, 16'd0, 16'd3000, 16'd50);
        run_random(80);
        // zero dt cap: virtual source holds still
        apply_setting(16'd2500, 16'd600, 16'd65535, 16'd65535, 16'd0);
        run_random(120);
        repeat (2) begin
            apply_setting(16'($urandom_range(1, 4095)), 16'($urandom_range(0, 4095)),
                          16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 1000)));
            run_random(170);
        end

        i_s_tvalid <= 1'b0;
        drain_results();
        $display("%0d updates checked under %0d register settings",
                 sb.checked, settings_used);
        $display("virtual source entered %0d times and left %0d times",
                 sb.entries, sb.exits);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
